// ----- hdl/assert_macros.svh -----
// assertion helpers used by the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

// ----- hdl/bvp_pkg.sv -----
package bvp_pkg;

   localparam int VOLT_W = 12;
   localparam int CNT_W  = 9;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   localparam int CSR_INDEX_W = 3;

   // register indexes of the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PACK_UNDER_LIMIT   = 3'd0,
      REG_CELL_UNDER_LIMIT   = 3'd1,
      REG_PACK_RECOVER_LEVEL = 3'd2,
      REG_CELL_RECOVER_LEVEL = 3'd3,
      REG_CELL_OVER_LIMIT    = 3'd4,
      REG_CELL_OVER_RELEASE  = 3'd5,
      REG_CELL_DEAD_LIMIT    = 3'd6,
      REG_CELL_LOW_RELEASE   = 3'd7
   } reg_index_type;

   typedef logic [VOLT_W-1:0] volt_type;
   typedef logic [CNT_W-1:0]  count_type;

   typedef struct packed {
      volt_type pack_under_limit;
      volt_type cell_under_limit;
      volt_type pack_recover_level;
      volt_type cell_recover_level;
      volt_type cell_over_limit;
      volt_type cell_over_release;
      volt_type cell_dead_limit;
      volt_type cell_low_release;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      pack_under_limit:   '0,
      cell_under_limit:   '0,
      pack_recover_level: '0,
      cell_recover_level: '0,
      cell_over_limit:    '1,
      cell_over_release:  '1,
      cell_dead_limit:    '0,
      cell_low_release:   '0
   };

   typedef struct packed {
      volt_type pack_voltage;
      volt_type cell_one;
      volt_type cell_two;
      volt_type cell_three;
      logic     charging;
      logic     charge_done;
      logic     fault_clear;
   } item_type;

   typedef struct packed {
      count_type under_count;
      count_type over_count;
      count_type low_count;
      count_type dead_count;
      logic      under_flag;
      logic      over_flag;
      logic      low_flag;
      logic      fault_flag;
      logic      ok_flag;
   } state_type;

   typedef struct packed {
      logic under_voltage;
      logic over_voltage;
      logic low_cell;
      logic cell_fault;
      logic battery_ok;
      logic restore_charge;
   } result_type;

endpackage

// ----- hdl/bvp_eval.sv -----
module bvp_eval #(
   parameter int UV_HOLD   = 250,
   parameter int OV_HOLD   = 100,
   parameter int DEAD_HOLD = 500
) (
   input  bvp_pkg::cfg_type    cfg,
   input  bvp_pkg::item_type   item,
   input  bvp_pkg::state_type  state_cur,
   output bvp_pkg::state_type  state_nxt,
   output bvp_pkg::result_type result
);
   import bvp_pkg::*;

   localparam count_type UV_LIM   = CNT_W'(UV_HOLD);
   localparam count_type OV_LIM   = CNT_W'(OV_HOLD);
   localparam count_type DEAD_LIM = CNT_W'(DEAD_HOLD);

   logic      cell_low;
   logic      cell_dead;
   logic      pack_low;
   logic      cell_over;
   logic      cells_below_release;
   logic      cells_recovered;
   logic      cells_low_released;
   logic      fault_pre;
   logic      restore;
   count_type under_inc;
   count_type over_inc;
   count_type low_inc;
   count_type dead_inc;

   // threshold compares on the pack and the three cells, and counter increments
   always_comb begin
      pack_low  = item.pack_voltage <= cfg.pack_under_limit;
      cell_low  = (item.cell_one <= cfg.cell_under_limit) ||
                  (item.cell_two <= cfg.cell_under_limit) ||
                  (item.cell_three <= cfg.cell_under_limit);
      cell_dead = (item.cell_one <= cfg.cell_dead_limit) ||
                  (item.cell_two <= cfg.cell_dead_limit) ||
                  (item.cell_three <= cfg.cell_dead_limit);
      cell_over = (item.cell_one >= cfg.cell_over_limit) ||
                  (item.cell_two >= cfg.cell_over_limit) ||
                  (item.cell_three >= cfg.cell_over_limit);
      cells_below_release = (item.cell_one <= cfg.cell_over_release) &&
                            (item.cell_two <= cfg.cell_over_release) &&
                            (item.cell_three <= cfg.cell_over_release);
      cells_recovered     = (item.cell_one >= cfg.cell_recover_level) &&
                            (item.cell_two >= cfg.cell_recover_level) &&
                            (item.cell_three >= cfg.cell_recover_level);
      cells_low_released  = (item.cell_one >= cfg.cell_low_release) &&
                            (item.cell_two >= cfg.cell_low_release) &&
                            (item.cell_three >= cfg.cell_low_release);
      under_inc = state_cur.under_count + 1'b1;
      over_inc  = state_cur.over_count + 1'b1;
      low_inc   = state_cur.low_count + 1'b1;
      dead_inc  = (state_cur.dead_count < CNT_MAX) ? state_cur.dead_count + 1'b1
                                                   : state_cur.dead_count;
   end

   // flag and counter update for one item
   always_comb begin
      state_nxt = state_cur;
      restore   = 1'b0;
      fault_pre = state_cur.fault_flag & ~item.fault_clear;
      state_nxt.fault_flag = fault_pre;

      // latched undervoltage
      if (pack_low || cell_low) begin
         if (under_inc >= UV_LIM) begin
            state_nxt.under_count = '0;
            state_nxt.under_flag  = 1'b1;
         end else begin
            state_nxt.under_count = under_inc;
         end
      end else begin
         state_nxt.under_count = '0;
         state_nxt.ok_flag     = 1'b1;
         if (state_cur.under_flag && (item.charging || item.charge_done) &&
             (item.pack_voltage >= cfg.pack_recover_level) && cells_recovered) begin
            state_nxt.under_flag = 1'b0;
         end
      end

      // overvoltage with hysteresis
      if (cell_over) begin
         if (over_inc >= OV_LIM) begin
            state_nxt.over_count = '0;
            state_nxt.over_flag  = 1'b1;
         end else begin
            state_nxt.over_count = over_inc;
         end
      end else if (cells_below_release) begin
         state_nxt.over_count = '0;
         state_nxt.over_flag  = 1'b0;
      end

      // low cell and deep discharge
      if (cell_low) begin
         if (low_inc >= UV_LIM) begin
            state_nxt.low_count = '0;
            state_nxt.low_flag  = 1'b1;
         end else begin
            state_nxt.low_count = low_inc;
         end
         if (cell_dead) begin
            state_nxt.dead_count = dead_inc;
            if (dead_inc >= DEAD_LIM) begin
               state_nxt.fault_flag = 1'b1;
            end
         end else begin
            state_nxt.dead_count = '0;
            state_nxt.ok_flag    = 1'b1;
         end
      end else if (cells_low_released && state_cur.low_flag) begin
         state_nxt.dead_count = '0;
         state_nxt.low_count  = '0;
         state_nxt.low_flag   = 1'b0;
         state_nxt.fault_flag = 1'b0;
         restore              = 1'b1;
      end
   end

   // result fields are the flags after the update plus the restore pulse
   always_comb begin
      result.under_voltage  = state_nxt.under_flag;
      result.over_voltage   = state_nxt.over_flag;
      result.low_cell       = state_nxt.low_flag;
      result.cell_fault     = state_nxt.fault_flag;
      result.battery_ok     = state_nxt.ok_flag;
      result.restore_charge = restore;
   end

endmodule

// ----- hdl/battery_voltage_protection_core.sv -----
// Battery protection monitor: each item carries one monitoring tick (pack voltage,
// three cell voltages, charger status, fault clear) and yields exactly one result
// item with the undervoltage, overvoltage, low-cell, deep-discharge fault and
// battery-ok flags plus a one-tick restore-charge pulse, all as they stand after
// that tick. An item is taken every clock while the result side keeps up; an input
// register feeds one pass of compare and counter logic into the result register,
// which is the only thing that holds the input back when the result side stalls.
// The user must write thresholds through the csr port only while no item is in
// flight; the block does not enforce this. An index selects one of eight registers.
`include "assert_macros.svh"

module battery_voltage_protection_core #(
   parameter int UV_HOLD   = 250,
   parameter int OV_HOLD   = 100,
   parameter int DEAD_HOLD = 500
) (
   input  logic                             clock,
   input  logic                             reset,
   // configuration writes
   input  logic                             csr_write,
   input  logic [bvp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bvp_pkg::VOLT_W-1:0]       csr_data,
   // input items
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [bvp_pkg::VOLT_W-1:0]       req_pack_voltage,
   input  logic [bvp_pkg::VOLT_W-1:0]       req_cell_one,
   input  logic [bvp_pkg::VOLT_W-1:0]       req_cell_two,
   input  logic [bvp_pkg::VOLT_W-1:0]       req_cell_three,
   input  logic                             req_charging,
   input  logic                             req_charge_done,
   input  logic                             req_fault_clear,
   // result items
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_under_voltage,
   output logic                             rsp_over_voltage,
   output logic                             rsp_low_cell,
   output logic                             rsp_cell_fault,
   output logic                             rsp_battery_ok,
   output logic                             rsp_restore_charge
);
   import bvp_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       stage_valid_ff, stage_valid_in;
   item_type   item_ff, item_in;
   state_type  state_ff, state_in;
   state_type  state_nxt;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type result_ff, result_in;
   result_type result_nxt;
   logic       advance;
   logic       take;
   logic       fire;

   // configuration register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_index_type'(csr_index))
            REG_PACK_UNDER_LIMIT:   cfg_in.pack_under_limit   = csr_data;
            REG_CELL_UNDER_LIMIT:   cfg_in.cell_under_limit   = csr_data;
            REG_PACK_RECOVER_LEVEL: cfg_in.pack_recover_level = csr_data;
            REG_CELL_RECOVER_LEVEL: cfg_in.cell_recover_level = csr_data;
            REG_CELL_OVER_LIMIT:    cfg_in.cell_over_limit    = csr_data;
            REG_CELL_OVER_RELEASE:  cfg_in.cell_over_release  = csr_data;
            REG_CELL_DEAD_LIMIT:    cfg_in.cell_dead_limit    = csr_data;
            REG_CELL_LOW_RELEASE:   cfg_in.cell_low_release   = csr_data;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   // handshake: stage moves on whenever the result register is free or draining
   always_comb begin
      advance   = !rsp_valid_ff || !rsp_stall;
      req_stall = stage_valid_ff && !advance;
      take      = req_valid && !req_stall;
      fire      = stage_valid_ff && advance;
   end

   // input register
   always_comb begin
      item_in        = item_ff;
      stage_valid_in = stage_valid_ff;
      if (take) begin
         item_in.pack_voltage = req_pack_voltage;
         item_in.cell_one     = req_cell_one;
         item_in.cell_two     = req_cell_two;
         item_in.cell_three   = req_cell_three;
         item_in.charging     = req_charging;
         item_in.charge_done  = req_charge_done;
         item_in.fault_clear  = req_fault_clear;
         stage_valid_in       = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
   end

   bvp_eval #(
      .UV_HOLD   (UV_HOLD),
      .OV_HOLD   (OV_HOLD),
      .DEAD_HOLD (DEAD_HOLD)
   ) u_eval (
      .cfg       (cfg_ff),
      .item      (item_ff),
      .state_cur (state_ff),
      .state_nxt (state_nxt),
      .result    (result_nxt)
   );

   // monitor state and result register
   always_comb begin
      state_in     = state_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         state_in     = state_nxt;
         result_in    = result_nxt;
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff         <= CFG_RESET;
         stage_valid_ff <= 1'b0;
         state_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         cfg_ff         <= cfg_in;
         stage_valid_ff <= stage_valid_in;
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   // result ports
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_under_voltage  = result_ff.under_voltage;
   assign rsp_over_voltage   = result_ff.over_voltage;
   assign rsp_low_cell       = result_ff.low_cell;
   assign rsp_cell_fault     = result_ff.cell_fault;
   assign rsp_battery_ok     = result_ff.battery_ok;
   assign rsp_restore_charge = result_ff.restore_charge;

   // checks
   `ASSERT_NEVER(a_restore_with_low, clock, reset, rsp_valid && rsp_restore_charge && rsp_low_cell)
   `ASSERT_NEVER(a_stall_empty_stage, clock, reset, req_stall && !stage_valid_ff)
   `ASSERT_PROP(a_ok_sticky, clock, reset, state_ff.ok_flag |=> state_ff.ok_flag)
   `ASSERT_NEVER(a_under_count_range, clock, reset, state_ff.under_count >= CNT_W'(UV_HOLD))
   `ASSERT_NEVER(a_over_count_range, clock, reset, state_ff.over_count >= CNT_W'(OV_HOLD))

endmodule
